FILE: hdl/icmp_echo_responder_assert.svh
// Assertion macros for the echo responder RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ICMP_ECHO_RESPONDER_ASSERT_SVH
`define ICMP_ECHO_RESPONDER_ASSERT_SVH

`ifndef SYNTHESIS
`define IECHO_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("iecho assertion failed");
`define IECHO_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("iecho assertion failed");
`else
`define IECHO_ASSERT(label, clk, rst, prop)
`define IECHO_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: hdl/iecho_pkg.sv
// Shared constants, types and helpers of the ICMP echo responder.
// No dependencies; imported by every module of the block.
package iecho_pkg;

  localparam int MAX_PACKET_BYTES = 1500;
  localparam int IP_HEADER_BYTES  = 20;
  localparam int POS_W            = 11;

  localparam int PROTO_OFFSET     = 9;
  localparam int TYPE_OFFSET      = IP_HEADER_BYTES;
  localparam int CSUM_HI_OFFSET   = IP_HEADER_BYTES + 2;
  localparam int CSUM_LO_OFFSET   = IP_HEADER_BYTES + 3;
  localparam int SEQ_HIGH_OFFSET  = 26;
  localparam int SEQ_LOW_OFFSET   = 27;
  localparam int HOLD_COUNT       = 8;
  localparam int HOLD_IDX_W       = $clog2(HOLD_COUNT);
  localparam int STEP_W           = $clog2(HOLD_COUNT + 2);

  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  TYPE_ECHO_REQ  = 8'd8;
  localparam logic [15:0] MAX_SEQ_RESET  = 16'd100;

  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_CSUM = 2'd1,
    KIND_DROP = 2'd2
  } kind_t;

  // One queued work item: reply bytes (one, or the held burst) and/or packet end.
  typedef struct packed {
    logic                      has_data;
    logic                      burst;
    logic [HOLD_COUNT*8-1:0]   bytes;
    logic                      has_end;
    logic                      accepted;
    logic [15:0]               csum;
  } entry_t;

  // Ones-complement add with end-around carry.
  function automatic logic [15:0] ones_add(input logic [15:0] s, input logic [15:0] w);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, w};
    return t[16] ? (t[15:0] + 16'd1) : t[15:0];
  endfunction

endpackage

FILE: hdl/iecho_queue.sv
// Short entry queue between the classifier and the result sequencer.
// Depends on iecho_pkg and icmp_echo_responder_assert.svh.
`include "icmp_echo_responder_assert.svh"

module iecho_queue
  import iecho_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   empty,
  output entry_t head
);

  entry_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  `IECHO_ASSERT(a_count_bound, clk, rst, count <= QCNT_W'(QUEUE_DEPTH))
  `IECHO_ASSERT(a_pop_nonempty, clk, rst, pop |-> count != '0)
  `IECHO_ASSERT(a_push_grows, clk, rst, (push && !pop) |=> count == $past(count) + 1'b1)

endmodule

FILE: hdl/iecho_front.sv
// Input side: tracks byte position, checks the header, holds the first ICMP
// bytes, keeps the running checksum and queues work entries. Uses iecho_pkg.
module iecho_front
  import iecho_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] packet_byte
  input  logic        s_tlast,
  input  logic [15:0] max_seq,
  input  logic        q_full,
  output logic        push,
  output entry_t      push_entry
);

  logic [POS_W-1:0] pos;
  logic             proto_ok;
  logic             type_ok;
  logic [7:0]       seq_high;
  logic             accepted;
  logic [15:0]      sum;
  logic [7:0]       pending;
  logic [7:0]       hold [HOLD_COUNT-1];

  logic             accept;
  logic             counted;
  logic             in_icmp;
  logic             decide;
  logic [7:0]       m;
  logic             accepted_next;
  logic [7:0]       pending_next;
  logic [POS_W-1:0] pos_next;
  logic [POS_W-1:0] hold_off;
  logic             word_add;
  logic             pad;
  logic [15:0]      word;
  logic [15:0]      sum_next;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    counted  = pos < POS_W'(MAX_PACKET_BYTES);
    in_icmp  = counted && (pos >= POS_W'(IP_HEADER_BYTES));
    decide   = counted && (pos == POS_W'(SEQ_LOW_OFFSET));
    hold_off = pos - POS_W'(IP_HEADER_BYTES);
    // type and checksum bytes are zeroed in the reply and in its sum
    m = ((pos == POS_W'(TYPE_OFFSET)) || (pos == POS_W'(CSUM_HI_OFFSET)) ||
         (pos == POS_W'(CSUM_LO_OFFSET))) ? 8'h00 : s_tdata;

    accepted_next = accepted;
    if (decide) accepted_next = proto_ok && type_ok && ({seq_high, s_tdata} <= max_seq);

    pending_next = (in_icmp && !pos[0]) ? m : pending;
    pos_next     = counted ? (pos + 1'b1) : pos;
    word_add     = in_icmp && pos[0];
    pad          = s_tlast && pos_next[0];
    word         = word_add ? {pending, m} : {pending_next, 8'h00};
    sum_next     = (word_add || pad) ? ones_add(sum, word) : sum;

    push_entry.has_data = (decide && accepted_next) ||
                          (counted && (pos > POS_W'(SEQ_LOW_OFFSET)) && accepted);
    push_entry.burst    = decide;
    push_entry.bytes    = '0;
    if (decide) begin
      for (int k = 0; k < HOLD_COUNT - 1; k++) push_entry.bytes[k*8 +: 8] = hold[k];
      push_entry.bytes[(HOLD_COUNT-1)*8 +: 8] = m;
    end else begin
      push_entry.bytes[7:0] = s_tdata;
    end
    push_entry.has_end  = s_tlast;
    push_entry.accepted = accepted_next;
    push_entry.csum     = ~sum_next;

    push = accept && (push_entry.has_data || push_entry.has_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      proto_ok <= 1'b0;
      type_ok  <= 1'b0;
      seq_high <= '0;
      accepted <= 1'b0;
      sum      <= '0;
      pending  <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        pos      <= '0;
        proto_ok <= 1'b0;
        type_ok  <= 1'b0;
        seq_high <= '0;
        accepted <= 1'b0;
        sum      <= '0;
        pending  <= '0;
      end else begin
        pos      <= pos_next;
        accepted <= accepted_next;
        sum      <= sum_next;
        pending  <= pending_next;
        if (counted && (pos == POS_W'(PROTO_OFFSET))) proto_ok <= (s_tdata == PROTO_ICMP);
        if (counted && (pos == POS_W'(TYPE_OFFSET)))  type_ok  <= (s_tdata == TYPE_ECHO_REQ);
        if (counted && (pos == POS_W'(SEQ_HIGH_OFFSET))) seq_high <= s_tdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_icmp && (pos < POS_W'(SEQ_LOW_OFFSET)))
      hold[hold_off[HOLD_IDX_W-1:0]] <= m;
  end

endmodule

FILE: hdl/iecho_back.sv
// Output side: expands queue entries into result items behind a register.
// Uses iecho_pkg.
module iecho_back
  import iecho_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  entry_t      head,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // [7:0] reply_byte, [23:8] reply_checksum
  output logic [1:0]  m_tuser,    // [1:0] result_kind
  output logic        m_tlast     // end_of_packet
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] nbytes;
  logic [STEP_W-1:0] total;
  logic              load;
  logic              emit_byte;
  kind_t             kind;

  always_comb begin
    nbytes    = head.has_data ? (head.burst ? STEP_W'(HOLD_COUNT) : STEP_W'(1)) : '0;
    total     = nbytes + STEP_W'(head.has_end);
    emit_byte = step < nbytes;
    load      = !q_empty && (!m_tvalid || m_tready);
    pop       = load && (step == total - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      step     <= '0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      step     <= pop ? '0 : (step + 1'b1);
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (emit_byte) begin
        kind    <= KIND_BYTE;
        m_tdata <= {16'h0000, head.bytes[step[HOLD_IDX_W-1:0]*8 +: 8]};
        m_tlast <= 1'b0;
      end else begin
        kind    <= head.accepted ? KIND_CSUM : KIND_DROP;
        m_tdata <= {(head.accepted ? head.csum : 16'h0000), 8'h00};
        m_tlast <= 1'b1;
      end
    end
  end

  assign m_tuser = kind;

endmodule

FILE: hdl/icmp_echo_responder.sv
// ICMP echo responder: one packet byte per cycle in while the queue is not full; a result
// item passes the queue write, then the output register, after the byte that causes it.
// Throughput is one item per cycle per side unless stalled; the eight bytes released at
// ICMP offset 7 leave one per cycle unless stalled; a full 8-entry queue stalls input.
// Synchronous active-high reset clears position, checks, sum, queue and output
// valid; max_seq resets to 100.
module icmp_echo_responder
  import iecho_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] packet_byte
  input  logic        s_tlast,    // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // [7:0] reply_byte, [23:8] reply_checksum
  output logic [1:0]  m_tuser,    // [1:0] result_kind
  output logic        m_tlast,    // end_of_packet
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata   // max_seq
);

  logic [15:0] max_seq;
  logic        q_full;
  logic        q_empty;
  logic        push;
  logic        pop;
  entry_t      push_entry;
  entry_t      head;

  always_ff @(posedge clk) begin
    if (rst) max_seq <= MAX_SEQ_RESET;
    else if (cfg_we) max_seq <= cfg_wdata;
  end

  iecho_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .max_seq    (max_seq),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  iecho_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (head)
  );

  iecho_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
